>>> hdl/krb_pkg.sv
// Shared types, command codes and the base64 character map for the challenge encoder.
`timescale 1ns / 1ps
`default_nettype none
package krb_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned KLEN_W  = 4;
  localparam int unsigned KIDX_W  = 3;
  localparam int unsigned PERM_DEPTH = 256;

  localparam logic [KEY_W-1:0]  KEY_RESET  = 64'd53199181329754;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd6;

  // Base64 alphabet anchors
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;  // 'A'
  localparam logic [CHAR_W-1:0] CH_LOWER_G = 7'd71;  // 'G', i.e. 'a' minus 26
  localparam logic [CHAR_W-1:0] CH_DIGIT_OFS = 7'd4; // value 52 maps to '0'
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'd43;    // '+'
  localparam logic [CHAR_W-1:0] CH_SLASH = 7'd47;    // '/'

  // Datapath operations issued by the controller
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_ACCEPT = 4'd1;  // take byte inside a challenge, issue read of index a
  localparam op_t OP_START  = 4'd2;  // take first byte, clear challenge state
  localparam op_t OP_CLR    = 4'd3;  // write identity entry
  localparam op_t OP_KRI    = 4'd4;  // key schedule: read perm[i]
  localparam op_t OP_KRJ    = 4'd5;  // key schedule: advance j, read perm[j]
  localparam op_t OP_KWJ    = 4'd6;  // key schedule: write perm[j]
  localparam op_t OP_KWI    = 4'd7;  // key schedule: write perm[i], advance i
  localparam op_t OP_RDA    = 4'd8;  // advance index a, read perm[a]
  localparam op_t OP_RDB    = 4'd9;  // advance index b, read and overwrite perm[b]
  localparam op_t OP_WRA    = 4'd10; // write perm[a], read perm[x+y]
  localparam op_t OP_FIN    = 4'd11; // XOR, group and emit

  typedef struct packed {
    op_t op;
  } krb_cmd_t;

  typedef struct packed {
    logic in_challenge;
    logic last_idx;
    logic stall;
  } krb_status_t;

  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + CH_UPPER_A;
    end else if (v < 6'd52) begin
      return w + CH_LOWER_G;
    end else if (v < 6'd62) begin
      return w - CH_DIGIT_OFS;
    end else if (v == 6'd62) begin
      return CH_PLUS;
    end
    return CH_SLASH;
  endfunction

endpackage
`default_nettype wire

>>> hdl/krb_in_if.sv
// Challenge byte channel: valid/ready handshake with byte and last-byte flag.
`timescale 1ns / 1ps
`default_nettype none
interface krb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] challenge_byte;
  logic       final_byte;

  modport source (output valid, output challenge_byte, output final_byte, input ready);
  modport sink   (input valid, input challenge_byte, input final_byte, output ready);
endinterface
`default_nettype wire

>>> hdl/krb_out_if.sv
// Response character channel: valid/ready handshake with character and end flags.
`timescale 1ns / 1ps
`default_nettype none
interface krb_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_response;
  logic       too_long;

  modport source (output valid, output out_char, output end_of_response, output too_long,
                  input ready);
  modport sink   (input valid, input out_char, input end_of_response, input too_long,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/keyed_challenge_response_base64_top.sv
// Top level: register port, controller and datapath of the keyed challenge encoder.
// Within a challenge each byte is handled in order: accept with read of perm[a], read and
// overwrite perm[b], write perm[a] with read of perm[x+y], then XOR and grouping.
// The first byte of a challenge runs an identity fill, a key schedule and a read of perm[a].
// Each key schedule entry swaps perm[i] and perm[j] over the single read and write port.
// Characters leave one per cycle on ready from a 4-entry buffer; a byte is taken as it drains.
// Reset is synchronous and active low; the permutation RAM is not cleared, it is rebuilt.
`timescale 1ns / 1ps
`default_nettype none
module keyed_challenge_response_base64_top #(
  parameter int unsigned MAX_LEN = 65,
  parameter int unsigned KEY_MAX = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  krb_in_if.sink           in_ch,
  krb_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);
  import krb_pkg::*;

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KLEN_W-1:0] klen_r, klen_nxt;
  logic              wr_en;
  krb_cmd_t          cmd;
  krb_status_t       status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? {{(64-KLEN_W){1'b0}}, klen_r} : key_r;

  always_comb begin
    key_nxt  = key_r;
    klen_nxt = klen_r;
    if (wr_en) begin
      if (paddr[3]) klen_nxt = pwdata[KLEN_W-1:0];
      else          key_nxt  = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= KEY_RESET;
      klen_r <= KLEN_RESET;
    end else begin
      key_r  <= key_nxt;
      klen_r <= klen_nxt;
    end
  end

  krb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  krb_dp #(.MAX_LEN(MAX_LEN), .KEY_MAX(KEY_MAX)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_byte    (in_ch.challenge_byte),
    .in_final   (in_ch.final_byte),
    .key_bytes  (key_r),
    .key_length (klen_r),
    .out_o      (out_ch)
  );

  // A transaction on the input side drops ready until the byte has been worked through
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after a transaction");

  // The overflow mark only rides on the final character
  a_toolong_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.too_long |-> out_ch.end_of_response)
    else $error("too_long set on a character that is not the last");

  // The grouping step is only ever entered from the step that writes perm[a]
  a_fin_from_wra: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN && $past(cmd.op) != OP_FIN |-> $past(cmd.op) == OP_WRA)
    else $error("grouping step entered out of sequence");

endmodule
`default_nettype wire

>>> hdl/krb_ram.sv
// Generic single-write, single-read RAM with registered read (returns old data on collision).
`timescale 1ns / 1ps
`default_nettype none
module krb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/krb_ctrl.sv
// Controller: sequences identity fill, key schedule and per-byte swap steps.
`timescale 1ns / 1ps
`default_nettype none
module krb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire krb_pkg::krb_status_t status,
  output krb_pkg::krb_cmd_t         cmd
);
  import krb_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_KRI  = 4'd2;
  localparam logic [3:0] ST_KRJ  = 4'd3;
  localparam logic [3:0] ST_KWJ  = 4'd4;
  localparam logic [3:0] ST_KWI  = 4'd5;
  localparam logic [3:0] ST_RDA  = 4'd6;
  localparam logic [3:0] ST_RDB  = 4'd7;
  localparam logic [3:0] ST_WRA  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (status.in_challenge) begin
            cmd.op    = OP_ACCEPT;
            state_nxt = ST_RDB;
          end else begin
            cmd.op    = OP_START;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cmd.op = OP_CLR;
        if (status.last_idx) state_nxt = ST_KRI;
      end
      ST_KRI: begin
        cmd.op    = OP_KRI;
        state_nxt = ST_KRJ;
      end
      ST_KRJ: begin
        cmd.op    = OP_KRJ;
        state_nxt = ST_KWJ;
      end
      ST_KWJ: begin
        cmd.op    = OP_KWJ;
        state_nxt = ST_KWI;
      end
      ST_KWI: begin
        cmd.op    = OP_KWI;
        state_nxt = status.last_idx ? ST_RDA : ST_KRI;
      end
      ST_RDA: begin
        cmd.op    = OP_RDA;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        cmd.op    = OP_RDB;
        state_nxt = ST_WRA;
      end
      ST_WRA: begin
        cmd.op    = OP_WRA;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold while the output buffer cannot take the group
        cmd.op = OP_FIN;
        if (!status.stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/krb_dp.sv
// Datapath: permutation RAM, indices, key schedule counters, grouping and output buffer.
`timescale 1ns / 1ps
`default_nettype none
module krb_dp #(
  parameter int unsigned MAX_LEN = 65,
  parameter int unsigned KEY_MAX = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire krb_pkg::krb_cmd_t            cmd,
  output krb_pkg::krb_status_t              status,
  input  wire logic [krb_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                         in_final,
  input  wire logic [krb_pkg::KEY_W-1:0]    key_bytes,
  input  wire logic [krb_pkg::KLEN_W-1:0]   key_length,
  krb_out_if.source                         out_o
);
  import krb_pkg::*;

  localparam int unsigned AW = $clog2(PERM_DEPTH);

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  krb_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state
  logic              inch_r, inch_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [2:0]        ocnt_r, ocnt_nxt;
  // Payload
  logic [BYTE_W-1:0] c_r, c_nxt;
  logic              fin_r, fin_nxt;
  logic [AW-1:0]     a_r, a_nxt, b_r, b_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [KIDX_W-1:0] k_r, k_nxt;
  logic [BYTE_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic              byp_r, byp_nxt;
  logic [BYTE_W-1:0] g0_r, g0_nxt, g1_r, g1_nxt;
  logic [CHAR_W-1:0] ch_r [4];
  logic [CHAR_W-1:0] ch_nxt [4];
  logic              last_r, last_nxt, tl_r, tl_nxt;

  // Helpers
  logic [KLEN_W-1:0] len_eff;
  logic [BYTE_W-1:0] kb, z, t, ep, eq, er, cnt_inc;
  logic              need_emit, obuf_free, stall, fire, ovf_inc, out_hs;
  logic [AW-1:0]     xy;

  assign len_eff = (key_length == '0) ? KLEN_W'(1) :
                   (key_length > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : key_length;
  assign kb      = key_bytes[{k_r, 3'b000} +: BYTE_W];
  assign xy      = x_r + y_r;
  assign z       = byp_r ? y_r : ram_rdata;
  assign t       = c_r ^ z;

  assign out_hs    = out_o.valid && out_o.ready;
  assign obuf_free = (ocnt_r == 3'd0) || ((ocnt_r == 3'd1) && out_o.ready);
  assign need_emit = (fill_r == 2'd2) || fin_r;
  assign stall     = need_emit && !obuf_free;
  assign fire      = (cmd.op == OP_FIN) && !stall;

  assign cnt_inc = (cnt_r != '1) ? cnt_r + BYTE_W'(1) : cnt_r;
  assign ovf_inc = ovf_r || (cnt_inc > BYTE_W'(MAX_LEN));

  // Group bytes handed to the encoder when this byte closes a group
  always_comb begin
    if (fill_r == 2'd2) begin
      ep = g0_r;
      eq = g1_r;
      er = t;
    end else if (fill_r == 2'd1) begin
      ep = g0_r;
      eq = t;
      er = '0;
    end else begin
      ep = t;
      eq = '0;
      er = '0;
    end
  end

  assign status.in_challenge = inch_r;
  assign status.last_idx     = (i_r == '1);
  assign status.stall        = stall;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = i_r;
    ram_raddr = i_r;
    inch_nxt  = inch_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    c_nxt     = c_r;
    fin_nxt   = fin_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    byp_nxt   = byp_r;
    g0_nxt    = g0_r;
    g1_nxt    = g1_r;
    last_nxt  = last_r;
    tl_nxt    = tl_r;
    ocnt_nxt  = ocnt_r;
    ch_nxt    = ch_r;

    if (out_hs) begin
      ocnt_nxt  = ocnt_r - 3'd1;
      ch_nxt[0] = ch_r[1];
      ch_nxt[1] = ch_r[2];
      ch_nxt[2] = ch_r[3];
    end

    unique case (cmd.op)
      OP_ACCEPT: begin
        c_nxt     = in_byte;
        fin_nxt   = in_final;
        a_nxt     = a_r + in_byte + AW'(1);
        ram_raddr = a_nxt;
      end
      OP_START: begin
        c_nxt    = in_byte;
        fin_nxt  = in_final;
        a_nxt    = '0;
        b_nxt    = '0;
        i_nxt    = '0;
        j_nxt    = '0;
        k_nxt    = '0;
        fill_nxt = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        inch_nxt = 1'b1;
      end
      OP_CLR: begin
        ram_we = 1'b1;
        i_nxt  = i_r + AW'(1);
      end
      OP_KRI: begin
        ram_raddr = i_r;
      end
      OP_KRJ: begin
        x_nxt     = ram_rdata;
        j_nxt     = j_r + ram_rdata + kb;
        ram_raddr = j_nxt;
      end
      OP_KWJ: begin
        y_nxt     = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = x_r;
      end
      OP_KWI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = y_r;
        i_nxt     = i_r + AW'(1);
        k_nxt     = (({1'b0, k_r} + KLEN_W'(1)) >= len_eff) ? '0 : k_r + KIDX_W'(1);
      end
      OP_RDA: begin
        a_nxt     = a_r + c_r + AW'(1);
        ram_raddr = a_nxt;
      end
      OP_RDB: begin
        // read returns the old perm[b] while x lands there
        x_nxt     = ram_rdata;
        b_nxt     = b_r + ram_rdata;
        ram_raddr = b_nxt;
        ram_we    = 1'b1;
        ram_waddr = b_nxt;
        ram_wdata = ram_rdata;
      end
      OP_WRA: begin
        y_nxt     = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = a_r;
        ram_wdata = ram_rdata;
        ram_raddr = x_r + ram_rdata;
        // perm[a] is written in the same cycle: forward it
        byp_nxt   = ((x_r + ram_rdata) == a_r);
      end
      OP_FIN: begin
        ram_raddr = xy;
        if (fire) begin
          cnt_nxt = cnt_inc;
          ovf_nxt = ovf_inc;
          if (fin_r) inch_nxt = 1'b0;
          if (need_emit) begin
            fill_nxt  = '0;
            ocnt_nxt  = 3'd4;
            ch_nxt[0] = b64_char(ep[7:2]);
            ch_nxt[1] = b64_char({ep[1:0], eq[7:4]});
            ch_nxt[2] = b64_char({eq[3:0], er[7:6]});
            ch_nxt[3] = b64_char(er[5:0]);
            last_nxt  = fin_r;
            tl_nxt    = fin_r && ovf_inc;
          end else begin
            if (fill_r[0]) g1_nxt = t;
            else           g0_nxt = t;
            fill_nxt = fill_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inch_r <= 1'b0;
      fill_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      ocnt_r <= '0;
      a_r    <= '0;
      b_r    <= '0;
      g0_r   <= '0;
      g1_r   <= '0;
    end else begin
      inch_r <= inch_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      ocnt_r <= ocnt_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      g0_r   <= g0_nxt;
      g1_r   <= g1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    fin_r  <= fin_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    byp_r  <= byp_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
    tl_r   <= tl_nxt;
  end

  assign out_o.valid           = (ocnt_r != 3'd0);
  assign out_o.out_char        = ch_r[0];
  assign out_o.end_of_response = last_r && (ocnt_r == 3'd1);
  assign out_o.too_long        = tl_r && (ocnt_r == 3'd1);

endmodule
`default_nettype wire

>>> test/keyed_challenge_response_base64_top_test.sv
// Self-checking testbench for the keyed challenge encoder: random handshakes, inline predictor.
`timescale 1ns / 1ps
module keyed_challenge_response_base64_top_test;
  import krb_pkg::*;

  localparam int unsigned LEN_LIMIT = 65;
  localparam int unsigned KEY_SLOTS = 8;
  localparam int unsigned SETTLE    = 1500;  // covers identity fill plus key schedule
  localparam logic [3:0]  ADDR_KEY  = 4'd0;
  localparam logic [3:0]  ADDR_KLEN = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } chal_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eor;
    logic              tl;
  } resp_char_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  krb_in_if  in_ch ();
  krb_out_if out_ch ();

  keyed_challenge_response_base64_top #(
    .MAX_LEN(LEN_LIMIT),
    .KEY_MAX(KEY_SLOTS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  chal_item_t chal_q[$];
  resp_char_t resp_q[$];
  int unsigned errors = 0;
  bit steady = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;

  // Predictor state
  logic [KEY_W-1:0]  key_cfg  = KEY_RESET;
  logic [KLEN_W-1:0] klen_cfg = KLEN_RESET;
  logic [7:0] sbox [PERM_DEPTH];
  logic [7:0] ptr_a = '0;
  logic [7:0] ptr_b = '0;
  logic [7:0] grp [2] = '{8'h00, 8'h00};
  logic [1:0] grp_fill = '0;
  logic [7:0] chal_len = '0;
  logic chal_overlong = 1'b0;
  logic chal_open = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("keyed_challenge_response_base64_top verification failed");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [CHAR_W-1:0] to_b64(input logic [5:0] v);
    if (v < 6'd26) return 7'd65 + 7'(v);
    if (v < 6'd52) return 7'd97 + 7'(v - 6'd26);
    if (v < 6'd62) return 7'd48 + 7'(v - 6'd52);
    if (v == 6'd62) return 7'd43;
    return 7'd47;
  endfunction

  task automatic emit_group(input logic [7:0] p, input logic [7:0] q, input logic [7:0] r,
                            input logic last);
    logic [5:0] sext [4];
    resp_char_t rc;
    sext[0] = p[7:2];
    sext[1] = {p[1:0], q[7:4]};
    sext[2] = {q[3:0], r[7:6]};
    sext[3] = r[5:0];
    for (int n = 0; n < 4; n++) begin
      rc.ch  = to_b64(sext[n]);
      rc.eor = last && (n == 3);
      rc.tl  = last && (n == 3) && chal_overlong;
      resp_q.push_back(rc);
    end
  endtask

  task automatic encode_byte(input logic [7:0] c, input logic fin);
    logic [7:0] x, y, t, q, j, sw, kb;
    int unsigned klen, k;
    if (!chal_open) begin
      klen = (klen_cfg == 0) ? 1 : ((klen_cfg > KEY_SLOTS) ? KEY_SLOTS : klen_cfg);
      for (int i = 0; i < PERM_DEPTH; i++) sbox[i] = 8'(i);
      j = '0;
      k = 0;
      for (int i = 0; i < PERM_DEPTH; i++) begin
        kb = key_cfg[8*k +: 8];
        j = j + sbox[i] + kb;
        sw = sbox[j];
        sbox[j] = sbox[i];
        sbox[i] = sw;
        k++;
        if (k >= klen) k = 0;
      end
      ptr_a = '0;
      ptr_b = '0;
      grp_fill = '0;
      chal_len = '0;
      chal_overlong = 1'b0;
      chal_open = 1'b1;
    end
    if (chal_len != 8'hFF) chal_len = chal_len + 8'd1;
    if (chal_len > LEN_LIMIT) chal_overlong = 1'b1;
    ptr_a = ptr_a + c + 8'd1;
    x = sbox[ptr_a];
    ptr_b = ptr_b + x;
    y = sbox[ptr_b];
    sbox[ptr_b] = x;
    sbox[ptr_a] = y;
    sw = x + y;
    t = c ^ sbox[sw];
    if (grp_fill == 2'd2) begin
      emit_group(grp[0], grp[1], t, fin);
      grp_fill = '0;
    end else begin
      grp[grp_fill[0]] = t;
      grp_fill = grp_fill + 2'd1;
      if (fin) begin
        q = (grp_fill == 2'd2) ? grp[1] : 8'h00;
        emit_group(grp[0], q, 8'h00, 1'b1);
        grp_fill = '0;
      end
    end
    if (fin) chal_open = 1'b0;
  endtask

  // Monitor: predict on accepted bytes, check accepted characters
  always @(posedge clk) begin : monitor
    logic took_in, took_out;
    resp_char_t got, want;
    took_in  = rst_n && in_ch.valid && in_ch.ready;
    took_out = rst_n && out_ch.valid && out_ch.ready;
    in_fire  <= took_in;
    out_fire <= took_out;
    if (took_in) encode_byte(in_ch.challenge_byte, in_ch.final_byte);
    if (took_out) begin
      got = '{out_ch.out_char, out_ch.end_of_response, out_ch.too_long};
      if (resp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual char=%h eor=%b too_long=%b",
                 $time, got.ch, got.eor, got.tl);
      end else begin
        want = resp_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b (char/eor/too_long)",
                   $time, want.ch, want.eor, want.tl, got.ch, got.eor, got.tl);
        end
      end
    end
  end

  // Byte driver
  always @(negedge clk) begin : drive_bytes
    chal_item_t item;
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (in_ch.valid) in_wait = draw_gap();
      if (in_wait == 0 && chal_q.size() > 0) begin
        item = chal_q.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.challenge_byte <= item.data;
        in_ch.final_byte     <= item.last;
      end else begin
        in_ch.valid <= 1'b0;
        if (in_wait > 0) in_wait--;
      end
    end
  end

  // Character sink: random stall, possibly none, after each transaction
  always @(negedge clk) begin : drive_ready
    if (rst_n && (out_fire || !out_ch.ready)) begin
      if (out_fire) out_wait = draw_gap();
      if (out_wait == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        out_wait--;
      end
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY) key_cfg = data;
    else klen_cfg = data[KLEN_W-1:0];
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    chal_q.push_back('{b, last});
  endtask

  task automatic push_random_challenge(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
  endtask

  // Hold until every byte is taken and every character has arrived, then let the block settle
  task automatic drain();
    while (chal_q.size() != 0 || in_ch.valid || resp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned n, len;
    logic [63:0] key;
    in_ch.valid = 1'b0;
    in_ch.challenge_byte = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset key: single byte, two-byte and three-byte tails, complete group mid-challenge
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);
    drain();

    // Zero key, length zero is taken as one
    reg_write(ADDR_KEY, 64'h0);
    reg_write(ADDR_KLEN, 64'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();

    // All-ones key at full, oversized and just-oversized lengths
    reg_write(ADDR_KEY, '1);
    reg_write(ADDR_KLEN, 64'd8);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC3, 1'b1);
    drain();
    reg_write(ADDR_KLEN, 64'd15);
    push_byte(8'hFF, 1'b1);
    drain();
    reg_write(ADDR_KLEN, 64'd9);
    push_byte(8'h3C, 1'b1);
    drain();

    // Key change inside an open challenge applies from the next challenge
    reg_write(ADDR_KLEN, 64'd1);
    reg_write(ADDR_KEY, {$urandom, $urandom});
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    drain();
    reg_write(ADDR_KEY, {$urandom, $urandom});
    reg_write(ADDR_KLEN, 64'd3);
    push_byte(8'h56, 1'b1);
    push_byte(8'h9A, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: key = 64'h0;
        1: key = '1;
        default: key = {$urandom, $urandom};
      endcase
      reg_write(ADDR_KEY, key);
      reg_write(ADDR_KLEN, {$urandom, 28'($urandom), 4'($urandom_range(0, 15))});
      steady = (ph == 3);
      if (ph == 0) push_random_challenge(LEN_LIMIT + 1);
      if (ph == 3) push_random_challenge(LEN_LIMIT);
      n = 0;
      while (n < 12) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(LEN_LIMIT - 1, LEN_LIMIT + 2)
                                            : $urandom_range(1, 12);
        push_random_challenge(len);
        n += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("keyed_challenge_response_base64_top verification clean");
    end else begin
      $display("keyed_challenge_response_base64_top verification failed");
    end
    $finish;
  end

endmodule

>>> keyed_challenge_response_base64_top.f
hdl/krb_pkg.sv
hdl/krb_in_if.sv
hdl/krb_out_if.sv
hdl/krb_ram.sv
hdl/krb_ctrl.sv
hdl/krb_dp.sv
hdl/keyed_challenge_response_base64_top.sv
test/keyed_challenge_response_base64_top_test.sv
